// File: src/pidrs_pkg.sv
// ============================================================================
// pidrs_pkg: shared types and constants for the point-in-region unit
// Widths, register codes and helpers for the disc / ring-sector point test.
// ============================================================================
`default_nettype none

package pidrs_pkg;

  // Coordinate width, signed Q16.8 at the default setting
  localparam int COORD_BITS = 24;

  // Magnitude of a coordinate difference fits COORD_BITS unsigned bits
  localparam int MAG_W     = COORD_BITS;
  localparam int SQ_FULL_W = 2 * MAG_W + 1;
  // Squared lengths and the dot product saturate at SQ_W bits, which is capped at 64
  localparam int SQ_W      = (SQ_FULL_W > 64) ? 64 : SQ_FULL_W;
  localparam int ROOT_W    = (SQ_W + 1) / 2;
  localparam int REM_W     = ROOT_W + 2;

  localparam int UCFG_W    = COORD_BITS - 1;
  localparam int COS_W     = 16;
  localparam int COS_FRAC  = 14;
  localparam int CFG_DW    = (COORD_BITS > COS_W) ? COORD_BITS : COS_W;
  localparam int CFG_IW    = 3;

  // Pipeline depth: front end, one root bit per stage, back end
  localparam int FRONT_ST  = 3;
  localparam int BACK_ST   = 4;
  localparam int NUM_ST    = FRONT_ST + ROOT_W + BACK_ST;

  // Back-end widths
  localparam int BAND_W    = ((ROOT_W > UCFG_W) ? ROOT_W : UCFG_W) + 1;
  localparam int PROD_W    = 2 * ROOT_W;
  localparam int HALF_W    = ROOT_W;
  localparam int PART_W    = HALF_W + COS_W;
  localparam int RHS_W     = PROD_W + COS_W;
  localparam int LHS_W     = SQ_W + COS_FRAC;
  localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef enum logic [1:0] {
    KIND_DISC = 2'd0,
    KIND_RING = 2'd1,
    KIND_ARC  = 2'd2,
    KIND_LINE = 2'd3
  } kind_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_KIND     = 3'd0,
    REG_POS_X    = 3'd1,
    REG_POS_Z    = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Z = 3'd4,
    REG_RADIUS   = 3'd5,
    REG_HALF_W   = 3'd6,
    REG_COS      = 3'd7
  } cfg_reg_e;

  // Front end result: squared lengths and signed dot product
  typedef struct packed {
    logic [SQ_W-1:0] q_sq;
    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] nmag;
    logic            nneg;
  } front_t;

  // Data riding alongside the root extraction
  typedef struct packed {
    logic [SQ_W-1:0] nmag;
    logic            nneg;
    logic            disc_hit;
  } side_t;

  // Clamp a full-width sum to the saturating width
  function automatic logic [SQ_W-1:0] sat_sq(input logic [SQ_FULL_W-1:0] s);
    logic [SQ_FULL_W-1:0] lim;
    lim = SQ_FULL_W'({SQ_W{1'b1}});
    if (s > lim) begin
      return {SQ_W{1'b1}};
    end
    return s[SQ_W-1:0];
  endfunction

  // Magnitude of a signed difference
  function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W:0] d);
    logic [MAG_W:0] n;
    n = d[MAG_W] ? (~d + 1'b1) : d;
    return n[MAG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/pidrs_front.sv
// ============================================================================
// pidrs_front: difference, square and sum stages
// Forms point and ring vectors, their squared lengths and the dot product.
// ============================================================================
`default_nettype none

module pidrs_front (
  input  wire logic                                   clk_i,
  input  wire logic [pidrs_pkg::FRONT_ST-1:0]         en_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] point_z_i,
  input  wire pidrs_pkg::kind_e                       kind_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] pos_x_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] pos_z_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] center_x_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] center_z_i,
  input  wire logic [pidrs_pkg::UCFG_W-1:0]           radius_i,
  output pidrs_pkg::front_t                           front_o
);

  localparam int CB = pidrs_pkg::COORD_BITS;
  localparam int MW = pidrs_pkg::MAG_W;
  localparam int PW = 2 * pidrs_pkg::MAG_W;

  // Stage A: vectors relative to the reference point
  logic            is_disc;
  logic [CB-1:0]   base_x, base_z;
  logic [CB:0]     qx_d, qz_d, rx_d, rz_d;

  assign is_disc = (kind_i == pidrs_pkg::KIND_DISC);
  assign base_x  = is_disc ? pos_x_i : center_x_i;
  assign base_z  = is_disc ? pos_z_i : center_z_i;
  assign qx_d    = {point_x_i[CB-1], point_x_i} - {base_x[CB-1], base_x};
  assign qz_d    = {point_z_i[CB-1], point_z_i} - {base_z[CB-1], base_z};
  // disc mode sends the radius down the ring lane so it comes out squared
  assign rx_d    = is_disc ? {2'b00, radius_i}
                           : ({pos_x_i[CB-1], pos_x_i} - {center_x_i[CB-1], center_x_i});
  assign rz_d    = is_disc ? '0
                           : ({pos_z_i[CB-1], pos_z_i} - {center_z_i[CB-1], center_z_i});

  logic [MW-1:0] qx_m_q, qz_m_q, rx_m_q, rz_m_q;
  logic          qx_n_q, qz_n_q, rx_n_q, rz_n_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      qx_m_q <= pidrs_pkg::mag_of(qx_d);
      qz_m_q <= pidrs_pkg::mag_of(qz_d);
      rx_m_q <= pidrs_pkg::mag_of(rx_d);
      rz_m_q <= pidrs_pkg::mag_of(rz_d);
      qx_n_q <= qx_d[CB];
      qz_n_q <= qz_d[CB];
      rx_n_q <= rx_d[CB];
      rz_n_q <= rz_d[CB];
    end
  end

  // Stage B: squares and dot product terms
  logic [PW-1:0] qx2_q, qz2_q, rx2_q, rz2_q, m1_q, m2_q;
  logic          s1_q, s2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      qx2_q <= qx_m_q * qx_m_q;
      qz2_q <= qz_m_q * qz_m_q;
      rx2_q <= rx_m_q * rx_m_q;
      rz2_q <= rz_m_q * rz_m_q;
      m1_q  <= rx_m_q * qx_m_q;
      m2_q  <= rz_m_q * qz_m_q;
      s1_q  <= rx_n_q ^ qx_n_q;
      s2_q  <= rz_n_q ^ qz_n_q;
    end
  end

  // Stage C: saturating sums and signed dot product
  logic [pidrs_pkg::SQ_FULL_W-1:0] q_sum, r_sum, m_sum;
  logic [PW-1:0]                   d12, d21;
  logic                            neg1, neg2;
  pidrs_pkg::front_t               front_d;

  assign q_sum = {1'b0, qx2_q} + {1'b0, qz2_q};
  assign r_sum = {1'b0, rx2_q} + {1'b0, rz2_q};
  assign m_sum = {1'b0, m1_q} + {1'b0, m2_q};
  assign d12   = m1_q - m2_q;
  assign d21   = m2_q - m1_q;
  assign neg1  = s1_q && (m1_q != '0);
  assign neg2  = s2_q && (m2_q != '0);

  always_comb begin
    front_d.q_sq = pidrs_pkg::sat_sq(q_sum);
    front_d.r_sq = pidrs_pkg::sat_sq(r_sum);
    if (neg1 == neg2) begin
      front_d.nmag = pidrs_pkg::sat_sq(m_sum);
      front_d.nneg = neg1;
    end else if (m1_q >= m2_q) begin
      front_d.nmag = pidrs_pkg::SQ_W'(d12);
      front_d.nneg = neg1;
    end else begin
      front_d.nmag = pidrs_pkg::SQ_W'(d21);
      front_d.nneg = neg2;
    end
    if (front_d.nmag == '0) begin
      front_d.nneg = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      front_o <= front_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pidrs_sqrt.sv
// ============================================================================
// pidrs_sqrt: pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ============================================================================
`default_nettype none

module pidrs_sqrt (
  input  wire logic                               clk_i,
  input  wire logic [pidrs_pkg::ROOT_W-1:0]       en_i,
  input  wire logic [pidrs_pkg::SQ_W-1:0]         radicand_i,
  output logic      [pidrs_pkg::ROOT_W-1:0]       root_o
);

  localparam int RW = pidrs_pkg::ROOT_W;
  localparam int EW = pidrs_pkg::REM_W;

  logic [2*RW-1:0] rad_q  [RW];
  logic [EW-1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [2*RW-1:0] rad_d;
    logic [EW-1:0]   rem_d;
    logic [RW-1:0]   root_d;
    logic [EW-1:0]   part, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rad_d  = (2*RW)'(radicand_i);
      assign rem_d  = '0;
      assign root_d = '0;
    end else begin : g_next
      assign rad_d  = rad_q[k-1];
      assign rem_d  = rem_q[k-1];
      assign root_d = root_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign part  = {rem_d[EW-3:0], rad_d[2*RW-1 -: 2]};
    assign trial = {root_d, 2'b01};
    assign ge    = (part >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rad_q[k]  <= rad_d << 2;
        rem_q[k]  <= ge ? (part - trial) : part;
        root_q[k] <= {root_d[RW-2:0], ge};
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

`default_nettype wire

// File: src/pidrs_back.sv
// ============================================================================
// pidrs_back: band, angle and decision stages
// Checks the ring band, scales the lengths by the cosine and decides.
// ============================================================================
`default_nettype none

module pidrs_back (
  input  wire logic                             clk_i,
  input  wire logic [pidrs_pkg::BACK_ST-1:0]    en_i,
  input  wire logic [pidrs_pkg::ROOT_W-1:0]     rd_i,
  input  wire logic [pidrs_pkg::ROOT_W-1:0]     rr_i,
  input  wire pidrs_pkg::side_t                 side_i,
  input  wire pidrs_pkg::kind_e                 kind_i,
  input  wire logic [pidrs_pkg::UCFG_W-1:0]     half_w_i,
  input  wire logic signed [pidrs_pkg::COS_W-1:0] cos_i,
  output logic                                  inside_o
);

  localparam int BW = pidrs_pkg::BAND_W;
  localparam int HW = pidrs_pkg::HALF_W;
  localparam int PW = pidrs_pkg::PROD_W;
  localparam int CW = pidrs_pkg::CMP_W;

  typedef struct packed {
    logic             band;
    logic             zero;
    pidrs_pkg::side_t side;
  } carry_t;

  // Stage E: band check and length product
  logic [BW-1:0] rd_w, rr_w, hw_w;
  carry_t        carry_d;
  carry_t        carry_e_q, carry_f_q, carry_g_q;
  logic [PW-1:0] prod_q;

  assign rd_w = BW'(rd_i);
  assign rr_w = BW'(rr_i);
  assign hw_w = BW'(half_w_i);

  always_comb begin
    carry_d.band = ((rd_w + hw_w) >= rr_w) && (rd_w <= (rr_w + hw_w));
    carry_d.zero = (rr_i == '0) || (rd_i == '0);
    carry_d.side = side_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q    <= rr_i * rd_i;
      carry_e_q <= carry_d;
    end
  end

  // Stage F: product times cosine magnitude, split in two halves
  logic [pidrs_pkg::COS_W-1:0]  cmag;
  logic [pidrs_pkg::PART_W-1:0] lo_q, hi_q;

  assign cmag = cos_i[pidrs_pkg::COS_W-1] ? (~cos_i + 1'b1) : cos_i;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      lo_q      <= prod_q[HW-1:0] * cmag;
      hi_q      <= prod_q[PW-1:HW] * cmag;
      carry_f_q <= carry_e_q;
    end
  end

  // Stage G: merge partial products
  logic [pidrs_pkg::RHS_W-1:0] rhs_q;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      rhs_q     <= (pidrs_pkg::RHS_W'(hi_q) << HW) + pidrs_pkg::RHS_W'(lo_q);
      carry_g_q <= carry_f_q;
    end
  end

  // Stage H: angle compare and final decision
  logic [CW-1:0] lhs, rhs;
  logic          cos_le0, ring_hit, inside_d;

  assign lhs     = CW'(carry_g_q.side.nmag) << pidrs_pkg::COS_FRAC;
  assign rhs     = CW'(rhs_q);
  assign cos_le0 = cos_i[pidrs_pkg::COS_W-1] || (cos_i == '0);

  always_comb begin
    if (!carry_g_q.band) begin
      ring_hit = 1'b0;
    end else if (carry_g_q.zero) begin
      // zero-length direction: dot counts as zero
      ring_hit = cos_le0;
    end else if (cos_le0) begin
      ring_hit = carry_g_q.side.nneg ? (lhs <= rhs) : 1'b1;
    end else if (carry_g_q.side.nneg || (carry_g_q.side.nmag == '0)) begin
      ring_hit = 1'b0;
    end else begin
      ring_hit = (lhs >= rhs);
    end
  end

  always_comb begin
    case (kind_i)
      pidrs_pkg::KIND_DISC: inside_d = carry_g_q.side.disc_hit;
      pidrs_pkg::KIND_RING: inside_d = ring_hit;
      default:              inside_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      inside_o <= inside_d;
    end
  end

endmodule

`default_nettype wire

// File: src/point_in_disc_or_ring_sector_unit.sv
// ============================================================================
// point_in_disc_or_ring_sector_unit: ground-plane point-in-region test
// Answers whether a query point lies in a disc or an annular sector.
// ============================================================================
// Usage:
//   Configuration registers are written over the cfg channel (index, data)
//   while no query is in flight; cfg_ready_o is always high.
//   Query points enter on the input channel (in_valid_i / in_stall_o) and one
//   result bit leaves per point on the output channel (out_valid_o /
//   out_stall_i), in order.
//   The pipeline depth NUM_ST grows with COORD_BITS and is set mostly by the
//   square root pipeline that extracts one root bit per stage. Throughput is
//   one point per cycle while the receiver does not stall.
//   Each stage has its own valid bit; a stage loads whenever it or any stage
//   after it is empty, so bubbles close up while the receiver stalls and new
//   points are taken until the pipe is full.
//   Reset clears all valid bits and loads the register defaults: disc mode,
//   all coordinates and widths zero, cosine threshold 1.0.
// ============================================================================
`default_nettype none

module point_in_disc_or_ring_sector_unit (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // query channel
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] point_x_i,
  input  wire logic signed [pidrs_pkg::COORD_BITS-1:0] point_z_i,
  // result channel
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic                                        inside_res_o,
  // configuration channel
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [pidrs_pkg::CFG_IW-1:0]           cfg_index_i,
  input  wire logic [pidrs_pkg::CFG_DW-1:0]           cfg_data_i
);

  localparam int CB = pidrs_pkg::COORD_BITS;
  localparam int NS = pidrs_pkg::NUM_ST;
  localparam int FS = pidrs_pkg::FRONT_ST;
  localparam int RW = pidrs_pkg::ROOT_W;

  // Configuration registers
  pidrs_pkg::kind_e                  kind_q;
  logic signed [CB-1:0]              pos_x_q, pos_z_q, center_x_q, center_z_q;
  logic [pidrs_pkg::UCFG_W-1:0]      radius_q, half_w_q;
  logic signed [pidrs_pkg::COS_W-1:0] cos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= pidrs_pkg::KIND_DISC;
      pos_x_q    <= '0;
      pos_z_q    <= '0;
      center_x_q <= '0;
      center_z_q <= '0;
      radius_q   <= '0;
      half_w_q   <= '0;
      cos_q      <= pidrs_pkg::COS_W'(1 << pidrs_pkg::COS_FRAC);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pidrs_pkg::cfg_reg_e'(cfg_index_i))
        pidrs_pkg::REG_KIND:     kind_q     <= pidrs_pkg::kind_e'(cfg_data_i[1:0]);
        pidrs_pkg::REG_POS_X:    pos_x_q    <= cfg_data_i[CB-1:0];
        pidrs_pkg::REG_POS_Z:    pos_z_q    <= cfg_data_i[CB-1:0];
        pidrs_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[CB-1:0];
        pidrs_pkg::REG_CENTER_Z: center_z_q <= cfg_data_i[CB-1:0];
        pidrs_pkg::REG_RADIUS:   radius_q   <= cfg_data_i[pidrs_pkg::UCFG_W-1:0];
        pidrs_pkg::REG_HALF_W:   half_w_q   <= cfg_data_i[pidrs_pkg::UCFG_W-1:0];
        pidrs_pkg::REG_COS:      cos_q      <= cfg_data_i[pidrs_pkg::COS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage loads when some stage at or after it is free
  logic [NS-1:0] en;
  logic [NS-1:0] v_q, v_d;

  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = ~out_stall_i | ~(&v_q[NS-1:k]);
  end

  always_comb begin
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = ~en[0];
  assign out_valid_o = v_q[NS-1];

  // Front end
  pidrs_pkg::front_t front;

  pidrs_front u_front (
    .clk_i      (clk_i),
    .en_i       (en[FS-1:0]),
    .point_x_i  (point_x_i),
    .point_z_i  (point_z_i),
    .kind_i     (kind_q),
    .pos_x_i    (pos_x_q),
    .pos_z_i    (pos_z_q),
    .center_x_i (center_x_q),
    .center_z_i (center_z_q),
    .radius_i   (radius_q),
    .front_o    (front)
  );

  // Root extraction for point distance and ring radius
  logic [RW-1:0] rd, rr;

  pidrs_sqrt u_sqrt_pt (
    .clk_i      (clk_i),
    .en_i       (en[FS+RW-1:FS]),
    .radicand_i (front.q_sq),
    .root_o     (rd)
  );

  pidrs_sqrt u_sqrt_ring (
    .clk_i      (clk_i),
    .en_i       (en[FS+RW-1:FS]),
    .radicand_i (front.r_sq),
    .root_o     (rr)
  );

  // Side data delayed to match the root pipeline
  pidrs_pkg::side_t side_d;
  pidrs_pkg::side_t side_q [RW];

  always_comb begin
    side_d.nmag     = front.nmag;
    side_d.nneg     = front.nneg;
    side_d.disc_hit = (front.q_sq <= front.r_sq);
  end

  for (genvar k = 0; k < RW; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[FS+k]) begin
        side_q[k] <= (k == 0) ? side_d : side_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // Back end
  pidrs_back u_back (
    .clk_i    (clk_i),
    .en_i     (en[NS-1:FS+RW]),
    .rd_i     (rd),
    .rr_i     (rr),
    .side_i   (side_q[RW-1]),
    .kind_i   (kind_q),
    .half_w_i (half_w_q),
    .cos_i    (cos_q),
    .inside_o (inside_res_o)
  );

`ifndef ASSERT_OFF
  // An accepted point lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted point missing from first stage");

  // Arc and line regions never report inside
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_q == pidrs_pkg::KIND_ARC || kind_q == pidrs_pkg::KIND_LINE))
      |-> !inside_res_o)
    else $error("arc or line region reported inside");

  // A stalled, valid output holds its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result lost");
`endif

endmodule

`default_nettype wire
